FILE: rtl/dnsq_pkg.sv
// shared types and constants for the dns question section parser
// no dependencies; used by dnsq_out_stage and dns_question_section_parser
package dnsq_pkg;

    // longest name accepted, closing zero included
    localparam int MAX_NAME_LEN = 255;

    // label bytes with either of these bits set are pointers or reserved types
    localparam logic [7:0] LABEL_TYPE_MASK = 8'hc0;

    // result kinds
    localparam logic KIND_NAME_BYTE = 1'b0;
    localparam logic KIND_STATUS    = 1'b1;

    // parser phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_LABEL,
        PH_TAIL,
        PH_DONE
    } phase_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic        ok;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [7:0]  name_length;
    } result_t;

endpackage

FILE: rtl/dnsq_out_stage.sv
// output register stage of the dns question parser: holds one result transfer
// depends on dnsq_pkg for result_t
module dnsq_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,       // new result this cycle
    input  dnsq_pkg::result_t load_data,
    output logic             can_take,   // stage free now or emptied this cycle
    output logic             m_tvalid,
    input  logic             m_tready,
    output dnsq_pkg::result_t out_data
);

    logic              valid_reg;
    logic              valid_next;
    dnsq_pkg::result_t data_reg;

    assign can_take = !valid_reg || m_tready;

    // valid flag: set on load, cleared once the result transfer completes
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds while stalled
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign out_data = data_reg;

endmodule

FILE: rtl/dns_question_section_parser.sv
// dns question section parser, top level: label walk, type/class gather
// depends on dnsq_pkg and dnsq_out_stage
//
// Usage:
//   The slave channel carries packet bytes one per transfer, starting at the
//   first byte of the question section (s_tuser high), with s_tlast on the
//   final byte of the packet buffer. Every name byte, closing zero included,
//   comes out on the master channel with m_tuser low; after the type and
//   class bytes a status result comes out with m_tuser high, carrying ok,
//   type, class and name length. A rejected question gives a status result
//   with ok low in place of the byte that failed. Bytes after a status
//   result are dropped until the next start mark.
//   Throughput is one byte per cycle while results are taken; a result
//   appears on the master side in the cycle after the byte that causes
//   it, set by the single output register. While the receiver stalls with
//   a result held, s_tready drops; it stays high in a cycle in which the
//   held result transfers. Reset puts the parser idle, waiting for a
//   start mark, with no result pending.
module dns_question_section_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_req
    input  logic        s_tlast,   // packet_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] name_byte, [8] ok, [24:9] query_type,
                                   // [40:25] query_class, [48:41] name_length
    output logic        m_tuser    // [0] kind
);

    localparam logic [9:0] MAX_LEN_W = 10'(dnsq_pkg::MAX_NAME_LEN);

    dnsq_pkg::phase_t phase_reg, phase_next;
    logic [8:0]  name_count_reg, name_count_next;
    logic [5:0]  label_left_reg, label_left_next;
    logic [1:0]  tail_count_reg, tail_count_next;
    logic [23:0] shift_reg, shift_next;

    logic              s_accept;
    logic              can_take;
    logic              res_valid;
    dnsq_pkg::result_t res;
    dnsq_pkg::result_t out_data;

    // state as seen by this byte, with a start mark restarting the parse
    dnsq_pkg::phase_t eff_phase;
    logic [8:0]  eff_count;
    logic [5:0]  eff_left;
    logic [1:0]  eff_tail;
    logic [23:0] eff_shift;
    logic [8:0]  count_inc;
    logic        zero_fail;
    logic        label_fail;

    assign s_tready = can_take;
    assign s_accept = s_tvalid && s_tready;

    assign eff_phase = s_tuser ? dnsq_pkg::PH_LEN : phase_reg;
    assign eff_count = s_tuser ? 9'd0  : name_count_reg;
    assign eff_left  = s_tuser ? 6'd0  : label_left_reg;
    assign eff_tail  = s_tuser ? 2'd0  : tail_count_reg;
    assign eff_shift = s_tuser ? 24'd0 : shift_reg;

    // checks on length and closing-zero bytes
    assign count_inc  = eff_count + 9'd1;
    assign zero_fail  = ({1'b0, count_inc} > MAX_LEN_W) || s_tlast;
    assign label_fail = ((s_tdata & dnsq_pkg::LABEL_TYPE_MASK) != 8'd0)
                     || (({1'b0, eff_count} + {2'b00, s_tdata} + 10'd2) > MAX_LEN_W)
                     || s_tlast;

    // next state
    always_comb begin
        phase_next      = eff_phase;
        name_count_next = eff_count;
        label_left_next = eff_left;
        tail_count_next = eff_tail;
        shift_next      = eff_shift;
        unique case (eff_phase)
            dnsq_pkg::PH_LEN: begin
                if (s_tdata == 8'd0) begin
                    name_count_next = count_inc;
                    tail_count_next = 2'd0;
                    shift_next      = 24'd0;
                    phase_next      = zero_fail ? dnsq_pkg::PH_DONE : dnsq_pkg::PH_TAIL;
                end else if (label_fail) begin
                    phase_next = dnsq_pkg::PH_DONE;
                end else begin
                    name_count_next = count_inc;
                    label_left_next = s_tdata[5:0];
                    phase_next      = dnsq_pkg::PH_LABEL;
                end
            end
            dnsq_pkg::PH_LABEL: begin
                if (s_tlast) begin
                    phase_next = dnsq_pkg::PH_DONE;
                end else begin
                    name_count_next = count_inc;
                    label_left_next = eff_left - 6'd1;
                    if (eff_left == 6'd1) begin
                        phase_next = dnsq_pkg::PH_LEN;
                    end
                end
            end
            dnsq_pkg::PH_TAIL: begin
                shift_next = {eff_shift[15:0], s_tdata};
                if (eff_tail == 2'd3 || s_tlast) begin
                    phase_next = dnsq_pkg::PH_DONE;
                end else begin
                    tail_count_next = eff_tail + 2'd1;
                end
            end
            default: begin
                phase_next = eff_phase;
            end
        endcase
    end

    // result for this byte
    always_comb begin
        res_valid       = 1'b0;
        res.kind        = dnsq_pkg::KIND_NAME_BYTE;
        res.name_byte   = 8'd0;
        res.ok          = 1'b0;
        res.query_type  = 16'd0;
        res.query_class = 16'd0;
        res.name_length = 8'd0;
        unique case (eff_phase)
            dnsq_pkg::PH_LEN: begin
                res_valid = 1'b1;
                if (s_tdata == 8'd0) begin
                    res.kind = zero_fail ? dnsq_pkg::KIND_STATUS : dnsq_pkg::KIND_NAME_BYTE;
                end else if (label_fail) begin
                    res.kind = dnsq_pkg::KIND_STATUS;
                end else begin
                    res.name_byte = s_tdata;
                end
            end
            dnsq_pkg::PH_LABEL: begin
                res_valid = 1'b1;
                if (s_tlast) begin
                    res.kind = dnsq_pkg::KIND_STATUS;
                end else begin
                    res.name_byte = s_tdata;
                end
            end
            dnsq_pkg::PH_TAIL: begin
                if (eff_tail == 2'd3) begin
                    res_valid       = 1'b1;
                    res.kind        = dnsq_pkg::KIND_STATUS;
                    res.ok          = 1'b1;
                    res.query_type  = eff_shift[23:8];
                    res.query_class = {eff_shift[7:0], s_tdata};
                    res.name_length = eff_count[7:0];
                end else if (s_tlast) begin
                    res_valid = 1'b1;
                    res.kind  = dnsq_pkg::KIND_STATUS;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // parser state registers, updated on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= dnsq_pkg::PH_IDLE;
            name_count_reg <= 9'd0;
            label_left_reg <= 6'd0;
            tail_count_reg <= 2'd0;
            shift_reg      <= 24'd0;
        end else if (s_accept) begin
            phase_reg      <= phase_next;
            name_count_reg <= name_count_next;
            label_left_reg <= label_left_next;
            tail_count_reg <= tail_count_next;
            shift_reg      <= shift_next;
        end
    end

    // result register toward the master side
    dnsq_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept && res_valid),
        .load_data (res),
        .can_take  (can_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_data  (out_data)
    );

    // pack the master payload
    assign m_tuser = out_data.kind;
    assign m_tdata = {7'd0, out_data.name_length, out_data.query_class,
                      out_data.query_type, out_data.ok, out_data.name_byte};

endmodule
